// ===== rtl/rsmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsmc_pkg
// Shared widths, register indexes, reset values and item types for the
// raster scan motor controller.
// ----------------------------------------------------------------------------
package rsmc_pkg;

    localparam int DIST_WIDTH   = 13;
    localparam int PITCH_WIDTH  = 8;
    localparam int TARGET_WIDTH = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = (DIST_WIDTH > PITCH_WIDTH) ? DIST_WIDTH : PITCH_WIDTH;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_LOW_BOUND  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH_BOUND = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW_BOUND  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH_BOUND = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = CFG_IDX_W'(4);

    // register reset values
    localparam logic [DIST_WIDTH-1:0]  RST_X_LOW_BOUND  = DIST_WIDTH'(200);
    localparam logic [DIST_WIDTH-1:0]  RST_X_HIGH_BOUND = DIST_WIDTH'(500);
    localparam logic [DIST_WIDTH-1:0]  RST_Y_LOW_BOUND  = DIST_WIDTH'(100);
    localparam logic [DIST_WIDTH-1:0]  RST_Y_HIGH_BOUND = DIST_WIDTH'(200);
    localparam logic [PITCH_WIDTH-1:0] RST_ROW_PITCH    = PITCH_WIDTH'(4);

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TOGGLE = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [DIST_WIDTH-1:0] x_mm;
        logic [DIST_WIDTH-1:0] y_mm;
    } t_in_item;

    typedef struct packed {
        logic       x_motor_stop;
        logic       y_motor_stop;
        logic       x_toward_high;
        logic       y_toward_high;
        logic       direction_known;
        logic [1:0] direction_code;
        logic       x_reversed;
        logic       y_target_active;
    } t_out_item;

endpackage

// ===== rtl/raster_scan_motor_controller_top.sv =====
// ----------------------------------------------------------------------------
// raster_scan_motor_controller_top
// Serpentine two-axis scan controller: turns X/Y distance samples and pause
// toggles into motor stop and direction pin levels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one command:
//   a pause/resume toggle or an X/Y distance sample. Output channel
//   (o_out_valid / i_out_stall / o_out_item) returns exactly one result item
//   per input item, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the bounds and
//   the row pitch by index; it is always ready. Write it only while idle.
//   An item lands in the input register at the accepting edge and its
//   result enters the output register once that is free. Throughput:
//   one item per cycle unless the receiver stalls, set by the single stage
//   of comparators and one 16-bit add/subtract that updates the scan state.
//   While the receiver stalls, the result holds and one more item can be
//   taken into the input register; after that o_in_stall rises.
//   Reset (i_rst_n low, synchronous) empties both registers, restores the
//   register defaults, sets running, clears the direction and row target
//   and sets both stop levels.
// ----------------------------------------------------------------------------
module raster_scan_motor_controller_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rsmc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rsmc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rsmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rsmc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DW = rsmc_pkg::DIST_WIDTH;
    localparam int TW = rsmc_pkg::TARGET_WIDTH;

    // configuration registers
    logic [DW-1:0]                    r_x_low, r_x_high, r_y_low, r_y_high;
    logic [rsmc_pkg::PITCH_WIDTH-1:0] r_pitch;

    // scan state
    logic          r_running, n_running;
    logic          r_dir_valid, n_dir_valid;
    logic [1:0]    r_dir_bits, n_dir_bits;
    logic [TW-1:0] r_target, n_target;
    logic          r_x_stop, n_x_stop;
    logic          r_y_stop, n_y_stop;
    logic          r_x_dir, n_x_dir;
    logic          r_y_dir, n_y_dir;

    // pipeline registers
    logic                r_in_valid;
    rsmc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    rsmc_pkg::t_out_item r_out, n_out;

    logic out_free, load_out, accept_in;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign load_out  = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept_in = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // next-state logic for the item in the input register
    logic signed [DW+1:0] sx, sy, x_lo_d, x_hi_d, y_lo_d, y_hi_d;
    logic [1:0]           d;
    logic                 reversed;
    logic [TW-1:0]        y16, pitch16, tgt;
    logic                 passed;

    always_comb begin
        sx      = $signed({2'b00, r_in.x_mm});
        sy      = $signed({2'b00, r_in.y_mm});
        x_lo_d  = sx - $signed({2'b00, r_x_low});
        x_hi_d  = $signed({2'b00, r_x_high}) - sx;
        y_lo_d  = sy - $signed({2'b00, r_y_low});
        y_hi_d  = $signed({2'b00, r_y_high}) - sy;
        y16     = TW'(r_in.y_mm);
        pitch16 = TW'(r_pitch);

        // bounds flip the direction bits; the high-bound test wins
        d = r_dir_bits;
        if (r_in.x_mm < r_x_low)  d[0] = 1'b1;
        if (r_in.x_mm > r_x_high) d[0] = 1'b0;
        if (r_in.y_mm < r_y_low)  d[1] = 1'b1;
        if (r_in.y_mm > r_y_high) d[1] = 1'b0;
        reversed = d[0] ^ r_dir_bits[0];

        tgt = r_target;
        if (reversed) begin
            tgt = d[1] ? (y16 + pitch16) : (y16 - pitch16);
        end
        passed = d[1] ? (y16 > tgt) : (y16 < tgt);

        n_running   = r_running;
        n_dir_valid = r_dir_valid;
        n_dir_bits  = r_dir_bits;
        n_target    = r_target;
        n_x_stop    = r_x_stop;
        n_y_stop    = r_y_stop;
        n_x_dir     = r_x_dir;
        n_y_dir     = r_y_dir;
        n_out.x_reversed = 1'b0;

        if (r_in.command == rsmc_pkg::CMD_TOGGLE) begin
            n_running = !r_running;
        end else if (!r_running) begin
            n_x_stop = 1'b1;
            n_y_stop = 1'b1;
        end else if (!r_dir_valid) begin
            // pick the starting corner from the nearer low bounds
            n_dir_bits  = {(x_lo_d < x_hi_d), (y_lo_d < y_hi_d)};
            n_dir_valid = 1'b1;
        end else begin
            n_dir_bits = d;
            n_x_dir    = d[0];
            n_y_dir    = d[1];
            n_out.x_reversed = reversed;
            if (reversed) begin
                n_x_stop = 1'b1;
            end
            if (tgt != '0) begin
                n_y_stop = passed;
                n_target = passed ? '0 : tgt;
            end else begin
                n_target = tgt;
                n_x_stop = 1'b0;
            end
        end

        n_out.x_motor_stop    = n_x_stop;
        n_out.y_motor_stop    = n_y_stop;
        n_out.x_toward_high   = n_x_dir;
        n_out.y_toward_high   = n_y_dir;
        n_out.direction_known = n_dir_valid;
        n_out.direction_code  = n_dir_bits;
        n_out.y_target_active = (n_target != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low     <= rsmc_pkg::RST_X_LOW_BOUND;
            r_x_high    <= rsmc_pkg::RST_X_HIGH_BOUND;
            r_y_low     <= rsmc_pkg::RST_Y_LOW_BOUND;
            r_y_high    <= rsmc_pkg::RST_Y_HIGH_BOUND;
            r_pitch     <= rsmc_pkg::RST_ROW_PITCH;
            r_running   <= 1'b1;
            r_dir_valid <= 1'b0;
            r_dir_bits  <= 2'b00;
            r_target    <= '0;
            r_x_stop    <= 1'b1;
            r_y_stop    <= 1'b1;
            r_x_dir     <= 1'b0;
            r_y_dir     <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rsmc_pkg::REG_X_LOW_BOUND:  r_x_low  <= i_cfg_data[DW-1:0];
                    rsmc_pkg::REG_X_HIGH_BOUND: r_x_high <= i_cfg_data[DW-1:0];
                    rsmc_pkg::REG_Y_LOW_BOUND:  r_y_low  <= i_cfg_data[DW-1:0];
                    rsmc_pkg::REG_Y_HIGH_BOUND: r_y_high <= i_cfg_data[DW-1:0];
                    rsmc_pkg::REG_ROW_PITCH: begin
                        r_pitch <= i_cfg_data[rsmc_pkg::PITCH_WIDTH-1:0];
                    end
                    default: ;
                endcase
            end

            if (load_out) begin
                r_running   <= n_running;
                r_dir_valid <= n_dir_valid;
                r_dir_bits  <= n_dir_bits;
                r_target    <= n_target;
                r_x_stop    <= n_x_stop;
                r_y_stop    <= n_y_stop;
                r_x_dir     <= n_x_dir;
                r_y_dir     <= n_y_dir;
            end

            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (load_out) begin
                r_in_valid <= 1'b0;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in <= i_in_item;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/rsmc_checker.sv =====
// ----------------------------------------------------------------------------
// rsmc_checker
// Port-level checks for the raster scan motor controller, bound to the top.
// ----------------------------------------------------------------------------
module rsmc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rsmc_pkg::t_out_item o_out_item
);

    // remember that a delivered item already reported a known direction
    logic r_seen_known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_known <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_item.direction_known) begin
            r_seen_known <= 1'b1;
        end
    end

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_item))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with output free");

    a_known_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_seen_known) |-> o_out_item.direction_known)
        else $error("direction became unknown again");

    a_reversal_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.x_reversed) |->
            (o_out_item.direction_known &&
             o_out_item.x_toward_high == o_out_item.direction_code[0]))
        else $error("reversal without matching X direction pin");

endmodule

bind raster_scan_motor_controller_top rsmc_checker u_rsmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
